// ----- design/tmma_pkg.sv -----
package tmma_pkg;

    localparam int MAX_SIZE = 32;
    localparam int TILE     = 8;

    localparam int IDX_W    = $clog2(MAX_SIZE);
    localparam int SZ_W     = $clog2(MAX_SIZE + 1);
    localparam int TW       = (TILE > 1) ? $clog2(TILE) : 1;
    localparam int DEPTH    = MAX_SIZE * MAX_SIZE;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CFG_W    = 6;
    localparam int AB_W     = 32;
    localparam int C_W      = 64;
    localparam int OP_W     = 3;

    localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(32);

    typedef enum logic [OP_W-1:0] {
        OP_WRITE_A = 3'd0,
        OP_WRITE_B = 3'd1,
        OP_WRITE_C = 3'd2,
        OP_COMPUTE = 3'd3,
        OP_READ_C  = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WAIT,
        S_LOAD,
        S_RUN,
        S_DRAIN,
        S_DONE
    } seq_state_t;

    // control from the sequencer to the MAC datapath
    typedef struct packed {
        logic load_c;     // C read issued this cycle, data lands next cycle
        logic issue_ab;   // A/B reads issued this cycle
    } mac_ctl_t;

    // clamp to MAX_SIZE, round down to a whole number of tiles
    function automatic logic [SZ_W-1:0] eff_size(input logic [CFG_W-1:0] ms);
        int m;
        m = (int'(ms) > MAX_SIZE) ? MAX_SIZE : int'(ms);
        return SZ_W'(m - (m % TILE));
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] r,
                                                 input logic [IDX_W-1:0] c);
        return ADDR_W'(r) * ADDR_W'(MAX_SIZE) + ADDR_W'(c);
    endfunction

endpackage

// ----- design/tmma_ram.sv -----
module tmma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/tmma_mac.sv -----
module tmma_mac (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tmma_pkg::mac_ctl_t           ctl,
    input  logic [tmma_pkg::AB_W-1:0]    a_rdata,
    input  logic [tmma_pkg::AB_W-1:0]    b_rdata,
    input  logic [tmma_pkg::C_W-1:0]     c_rdata,
    output logic [tmma_pkg::C_W-1:0]     acc,
    output logic                         busy
);
    import tmma_pkg::*;

    logic                   load_d_reg;
    logic                   ab_v_reg;
    logic                   prod_v_reg;
    logic signed [C_W-1:0]  prod_reg;
    logic signed [C_W-1:0]  prod_next;
    logic signed [C_W-1:0]  acc_reg;
    logic signed [C_W-1:0]  acc_next;
    logic signed [C_W-1:0]  sum;
    logic signed [AB_W-1:0] a_s;
    logic signed [AB_W-1:0] b_s;

    assign a_s       = a_rdata;
    assign b_s       = b_rdata;
    assign prod_next = a_s * b_s;   // exact Q32.32

    // saturating add
    always_comb
    begin
        sum = acc_reg + prod_reg;
        if (acc_reg[C_W-1] == prod_reg[C_W-1] && sum[C_W-1] != acc_reg[C_W-1])
        begin
            acc_next = acc_reg[C_W-1] ? {1'b1, {(C_W-1){1'b0}}}
                                      : {1'b0, {(C_W-1){1'b1}}};
        end
        else
        begin
            acc_next = sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_d_reg <= 1'b0;
            ab_v_reg   <= 1'b0;
            prod_v_reg <= 1'b0;
        end
        else
        begin
            load_d_reg <= ctl.load_c;
            ab_v_reg   <= ctl.issue_ab;
            prod_v_reg <= ab_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ab_v_reg)
        begin
            prod_reg <= prod_next;
        end
        if (load_d_reg)
        begin
            acc_reg <= c_rdata;
        end
        else if (prod_v_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc  = acc_reg;
    assign busy = ab_v_reg | prod_v_reg;

endmodule

// ----- design/tmma_seq.sv -----
module tmma_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tmma_pkg::SZ_W-1:0]     n,
    input  logic                          p1_empty,
    input  logic                          p1_free,
    input  logic                          mac_busy,
    output logic                          busy,
    output logic                          done_push,
    output logic                          ab_re,
    output logic [tmma_pkg::ADDR_W-1:0]   a_raddr,
    output logic [tmma_pkg::ADDR_W-1:0]   b_raddr,
    output logic                          c_re,
    output logic [tmma_pkg::ADDR_W-1:0]   c_raddr,
    output logic                          c_we,
    output logic [tmma_pkg::ADDR_W-1:0]   c_waddr,
    output tmma_pkg::mac_ctl_t            mac_ctl
);
    import tmma_pkg::*;

    seq_state_t       state_reg, state_next;
    logic [IDX_W-1:0] rb_reg, rb_next;
    logic [IDX_W-1:0] cb_reg, cb_next;
    logic [TW-1:0]    ri_reg, ri_next;
    logic [TW-1:0]    ci_reg, ci_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             k_last;
    logic             ri_end;
    logic             ci_end;
    logic             rb_end;
    logic             cb_end;

    assign row    = rb_reg + IDX_W'(ri_reg);
    assign col    = cb_reg + IDX_W'(ci_reg);
    assign k_last = (SZ_W'(k_reg) + SZ_W'(1)) == n;
    assign ri_end = ri_reg == TW'(TILE - 1);
    assign ci_end = ci_reg == TW'(TILE - 1);
    assign rb_end = (SZ_W'(rb_reg) + SZ_W'(TILE)) == n;
    assign cb_end = (SZ_W'(cb_reg) + SZ_W'(TILE)) == n;

    assign a_raddr = addr_of(row, k_reg);
    assign b_raddr = addr_of(k_reg, col);
    assign c_raddr = addr_of(row, col);
    assign c_waddr = addr_of(row, col);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rb_reg    <= '0;
            cb_reg    <= '0;
            ri_reg    <= '0;
            ci_reg    <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rb_reg    <= rb_next;
            cb_reg    <= cb_next;
            ri_reg    <= ri_next;
            ci_reg    <= ci_next;
            k_reg     <= k_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        rb_next          = rb_reg;
        cb_next          = cb_reg;
        ri_next          = ri_reg;
        ci_next          = ci_reg;
        k_next           = k_reg;
        busy             = 1'b1;
        done_push        = 1'b0;
        ab_re            = 1'b0;
        c_re             = 1'b0;
        c_we             = 1'b0;
        mac_ctl.load_c   = 1'b0;
        mac_ctl.issue_ab = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                // C read port is shared with a read still held in stage 1
                if (p1_empty)
                begin
                    rb_next = '0;
                    cb_next = '0;
                    ri_next = '0;
                    ci_next = '0;
                    state_next = (n == '0) ? S_DONE : S_LOAD;
                end
            end
            S_LOAD:
            begin
                c_re           = 1'b1;
                mac_ctl.load_c = 1'b1;
                k_next         = '0;
                state_next     = S_RUN;
            end
            S_RUN:
            begin
                ab_re            = 1'b1;
                mac_ctl.issue_ab = 1'b1;
                k_next           = k_reg + IDX_W'(1);
                if (k_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!mac_busy)
                begin
                    c_we       = 1'b1;
                    state_next = S_LOAD;
                    if (ci_end)
                    begin
                        ci_next = '0;
                        if (ri_end)
                        begin
                            ri_next = '0;
                            if (cb_end)
                            begin
                                cb_next = '0;
                                if (rb_end)
                                begin
                                    rb_next    = '0;
                                    state_next = S_DONE;
                                end
                                else
                                begin
                                    rb_next = rb_reg + IDX_W'(TILE);
                                end
                            end
                            else
                            begin
                                cb_next = cb_reg + IDX_W'(TILE);
                            end
                        end
                        else
                        begin
                            ri_next = ri_reg + TW'(1);
                        end
                    end
                    else
                    begin
                        ci_next = ci_reg + TW'(1);
                    end
                end
            end
            S_DONE:
            begin
                if (p1_free)
                begin
                    done_push  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- design/tiled_matrix_multiply_accumulate_core.sv -----
// Channel   Dir  Word                                  Handshake
// s_axis    in   opcode, row, col, ab_value, c_value   s_tvalid / s_tready
// m_axis    out  read_value, status                    m_tvalid / m_tready
// cfg       in   matrix_size                           cfg_wr_en, no wait
//
// Element writes and reads take one word per clock when s_tready is high;
// each result passes through stage 1 and the output register. A compute
// holds s_tready low while it works one C element at a time: C read, n
// inner steps through the single A/B read ports and one multiplier, then
// drain and write; wait and done states start it and post the result.
// Reset clears control only; the matrix memories hold garbage until written.
// m_tready low stalls the output register, then stage 1, then s_tready.
module tiled_matrix_multiply_accumulate_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [2:0] opcode
    input  logic [tmma_pkg::OP_W-1:0]     s_tuser,
    // [4:0] row, [9:5] col, [41:10] ab_value, [105:42] c_value,
    // [111:106] zero
    input  logic [111:0]                  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [63:0] read_value
    output logic [63:0]                   m_tdata,
    // [0] status
    output logic                          m_tuser,
    input  logic                          cfg_wr_en,
    input  logic [tmma_pkg::CFG_W-1:0]    cfg_wr_data
);
    import tmma_pkg::*;

    // input word fields
    logic [OP_W-1:0]  opcode;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [AB_W-1:0]  ab_value;
    logic [C_W-1:0]   c_value;

    assign opcode   = s_tuser;
    assign row      = s_tdata[4:0];
    assign col      = s_tdata[9:5];
    assign ab_value = s_tdata[41:10];
    assign c_value  = s_tdata[105:42];

    // effective size, clamped and rounded at config write time
    logic [SZ_W-1:0] n_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg <= eff_size(SIZE_RESET);
        end
        else if (cfg_wr_en)
        begin
            n_reg <= eff_size(cfg_wr_data);
        end
    end

    // stage 1: memory access in flight; out: result register
    logic            p1_v_reg;
    logic            p1_rd_reg;
    logic            p1_st_reg;
    logic            out_v_reg;
    logic [C_W-1:0]  out_val_reg;
    logic            out_st_reg;
    logic            p1_adv;
    logic            accept;

    // sequencer hookup
    logic              seq_busy;
    logic              done_push;
    logic              seq_ab_re;
    logic [ADDR_W-1:0] seq_a_raddr;
    logic [ADDR_W-1:0] seq_b_raddr;
    logic              seq_c_re;
    logic [ADDR_W-1:0] seq_c_raddr;
    logic              seq_c_we;
    logic [ADDR_W-1:0] seq_c_waddr;
    mac_ctl_t          mac_ctl;
    logic              mac_busy;
    logic [C_W-1:0]    acc;

    // memory ports
    logic [AB_W-1:0]   a_rdata;
    logic [AB_W-1:0]   b_rdata;
    logic [C_W-1:0]    c_rdata;
    logic              a_we;
    logic              b_we;
    logic              c_we;
    logic [ADDR_W-1:0] c_waddr;
    logic [C_W-1:0]    c_wdata;
    logic              c_re;
    logic [ADDR_W-1:0] c_raddr;
    logic [ADDR_W-1:0] item_addr;

    // item decode
    logic oor;
    logic item_st;
    logic item_rd;
    logic item_wa;
    logic item_wb;
    logic item_wc;
    logic item_cmp;

    assign p1_adv   = p1_v_reg && (!out_v_reg || m_tready);
    assign s_tready = !seq_busy && (!p1_v_reg || p1_adv);
    assign accept   = s_tvalid && s_tready;

    assign oor       = (SZ_W'(row) >= n_reg) || (SZ_W'(col) >= n_reg);
    assign item_addr = addr_of(row, col);

    always_comb
    begin
        item_st  = 1'b0;
        item_rd  = 1'b0;
        item_wa  = 1'b0;
        item_wb  = 1'b0;
        item_wc  = 1'b0;
        item_cmp = 1'b0;
        case (opcode)
            OP_WRITE_A:
            begin
                item_st = oor;
                item_wa = !oor;
            end
            OP_WRITE_B:
            begin
                item_st = oor;
                item_wb = !oor;
            end
            OP_WRITE_C:
            begin
                item_st = oor;
                item_wc = !oor;
            end
            OP_COMPUTE:
            begin
                item_cmp = 1'b1;
            end
            OP_READ_C:
            begin
                item_st = oor;
                item_rd = !oor;
            end
            default:
            begin
                item_st = 1'b0;   // unused codes: no effect
            end
        endcase
    end

    assign a_we    = accept && item_wa;
    assign b_we    = accept && item_wb;
    // item and compute never touch C in the same cycle
    assign c_we    = (accept && item_wc) || seq_c_we;
    assign c_waddr = seq_c_we ? seq_c_waddr : item_addr;
    assign c_wdata = seq_c_we ? acc : c_value;
    assign c_re    = (accept && item_rd) || seq_c_re;
    assign c_raddr = seq_c_re ? seq_c_raddr : item_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if ((accept && !item_cmp) || done_push)
            begin
                p1_v_reg <= 1'b1;
            end
            else if (p1_adv)
            begin
                p1_v_reg <= 1'b0;
            end
            if (p1_adv)
            begin
                out_v_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_push)
        begin
            p1_rd_reg <= 1'b0;
            p1_st_reg <= 1'b0;
        end
        else if (accept)
        begin
            p1_rd_reg <= item_rd;
            p1_st_reg <= item_st;
        end
        if (p1_adv)
        begin
            // C read data stays put until the word moves on
            out_val_reg <= p1_rd_reg ? c_rdata : '0;
            out_st_reg  <= p1_st_reg;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_val_reg;
    assign m_tuser  = out_st_reg;

    tmma_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept && item_cmp),
        .n         (n_reg),
        .p1_empty  (!p1_v_reg),
        .p1_free   (!p1_v_reg || p1_adv),
        .mac_busy  (mac_busy),
        .busy      (seq_busy),
        .done_push (done_push),
        .ab_re     (seq_ab_re),
        .a_raddr   (seq_a_raddr),
        .b_raddr   (seq_b_raddr),
        .c_re      (seq_c_re),
        .c_raddr   (seq_c_raddr),
        .c_we      (seq_c_we),
        .c_waddr   (seq_c_waddr),
        .mac_ctl   (mac_ctl)
    );

    tmma_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mac_ctl),
        .a_rdata (a_rdata),
        .b_rdata (b_rdata),
        .c_rdata (c_rdata),
        .acc     (acc),
        .busy    (mac_busy)
    );

    tmma_ram #(.WIDTH(AB_W), .DEPTH(DEPTH)) u_a_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (item_addr),
        .wdata (ab_value),
        .re    (seq_ab_re),
        .raddr (seq_a_raddr),
        .rdata (a_rdata)
    );

    tmma_ram #(.WIDTH(AB_W), .DEPTH(DEPTH)) u_b_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (item_addr),
        .wdata (ab_value),
        .re    (seq_ab_re),
        .raddr (seq_b_raddr),
        .rdata (b_rdata)
    );

    tmma_ram #(.WIDTH(C_W), .DEPTH(DEPTH)) u_c_ram (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .re    (c_re),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

endmodule

// ----- test/tiled_matrix_multiply_accumulate_core_tb.sv -----
`timescale 1ns / 100ps

module tiled_matrix_multiply_accumulate_core_tb;
    import tmma_pkg::*;

    // opcodes the block leaves unused: accepted, answered with zero and status 0
    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

    localparam logic signed [C_W-1:0]  C_MAX  = {1'b0, {(C_W-1){1'b1}}};
    localparam logic signed [C_W-1:0]  C_MIN  = {1'b1, {(C_W-1){1'b0}}};
    localparam logic signed [AB_W-1:0] AB_MAX = {1'b0, {(AB_W-1){1'b1}}};
    localparam logic signed [AB_W-1:0] AB_MIN = {1'b1, {(AB_W-1){1'b0}}};

    // results pass through stage 1 and the output register; settle after the last one
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_STALL    = 300;
    localparam int RUN_WORDS     = 80;
    localparam int PRESSURE_WORDS = 30;
    // slowest legal compute here is n = 32; this bound leaves a wide margin
    localparam int LIMIT_NS      = 10_000_000;

    typedef struct {
        logic signed [C_W-1:0] read_value;
        logic                  status;
    } result_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    // [2:0] opcode
    logic [OP_W-1:0]   s_tuser;
    // [4:0] row, [9:5] col, [41:10] ab_value, [105:42] c_value,
    // [111:106] zero
    logic [111:0]      s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    // [63:0] read_value
    logic [63:0]       m_tdata;
    // [0] status
    logic              m_tuser;
    logic              cfg_wr_en;
    logic [CFG_W-1:0]  cfg_wr_data;

    // shadow copy of the matrices and the size register
    logic signed [AB_W-1:0] a_mem [DEPTH];
    logic signed [AB_W-1:0] b_mem [DEPTH];
    logic signed [C_W-1:0]  c_mem [DEPTH];
    bit                     a_set [DEPTH];
    bit                     b_set [DEPTH];
    bit                     c_set [DEPTH];
    logic [CFG_W-1:0]       size_reg;

    result_t pending_results [$];
    int      mismatch_count;
    int      tx_idle_pct;
    int      rx_idle_pct;
    int      stall_left;

    tiled_matrix_multiply_accumulate_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // size actually used: clamp to MAX_SIZE, then drop any partial tile
    function automatic int active_size();
        int m;
        m = int'(size_reg);
        if (m > MAX_SIZE)
            m = MAX_SIZE;
        return m - (m % TILE);
    endfunction

    // signed 64-bit add that pins at the rails instead of wrapping
    function automatic logic signed [C_W-1:0] sat_sum(input logic signed [C_W-1:0] x,
                                                      input logic signed [C_W-1:0] y);
        logic signed [C_W:0] s;
        s = x + y;
        if (s[C_W] != s[C_W-1])
            return s[C_W] ? C_MIN : C_MAX;
        return s[C_W-1:0];
    endfunction

    // C += A*B over the n x n corner. Tiling only changes the order in which
    // elements are visited; each element still sums k in ascending order.
    function automatic void multiply_accumulate(input int n);
        logic signed [C_W-1:0] acc;
        logic signed [C_W-1:0] prod;
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
            begin
                acc = c_mem[r * MAX_SIZE + c];
                for (int k = 0; k < n; k++)
                begin
                    prod = a_mem[r * MAX_SIZE + k] * b_mem[k * MAX_SIZE + c];
                    acc  = sat_sum(acc, prod);
                end
                c_mem[r * MAX_SIZE + c] = acc;
            end
    endfunction

    // applies one accepted word to the shadow state, returns its result word
    function automatic result_t mac_engine_step(input logic [OP_W-1:0]  op,
                                                input logic [IDX_W-1:0] row,
                                                input logic [IDX_W-1:0] col,
                                                input logic [AB_W-1:0]  ab,
                                                input logic [C_W-1:0]   cv);
        result_t res;
        int      n;
        int      idx;
        res.read_value = '0;
        res.status     = 1'b0;
        n   = active_size();
        idx = int'(row) * MAX_SIZE + int'(col);
        if (op == OP_COMPUTE)
            multiply_accumulate(n);
        else if (op <= OP_READ_C)
        begin
            if (int'(row) >= n || int'(col) >= n)
                res.status = 1'b1;
            else
                case (op)
                    OP_WRITE_A:
                    begin
                        a_mem[idx] = ab;
                        a_set[idx] = 1'b1;
                    end
                    OP_WRITE_B:
                    begin
                        b_mem[idx] = ab;
                        b_set[idx] = 1'b1;
                    end
                    OP_WRITE_C:
                    begin
                        c_mem[idx] = cv;
                        c_set[idx] = 1'b1;
                    end
                    default:
                        res.read_value = c_mem[idx];
                endcase
        end
        return res;
    endfunction

    // a compute reads every A, B and C entry inside n x n; all must be written
    function automatic bit region_ready(input int n);
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
                if (!(a_set[r * MAX_SIZE + c] && b_set[r * MAX_SIZE + c] &&
                      c_set[r * MAX_SIZE + c]))
                    return 1'b0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Driving side
    // ------------------------------------------------------------------

    // offers one word at the falling edge, with an optional random gap first,
    // and books its expected result at the rising edge that takes it
    task automatic send_word(input logic [OP_W-1:0]  op,
                             input logic [IDX_W-1:0] row,
                             input logic [IDX_W-1:0] col,
                             input logic [AB_W-1:0]  ab,
                             input logic [C_W-1:0]   cv);
        @(negedge clk);
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(0, 99) < tx_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'b000000, cv, ab, col, row};
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(mac_engine_step(op, row, col, ab, cv));
    endtask

    // drop valid, then wait until every booked result has come back
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // size register may only change while the block is idle
    task automatic set_size(input logic [CFG_W-1:0] value);
        drain_results();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        size_reg     = value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [AB_W-1:0] rand_ab();
        if ($urandom_range(0, 2) == 0)
            return AB_W'(int'($urandom_range(0, 262143)) - 131072);
        return $urandom;
    endfunction

    function automatic logic [C_W-1:0] rand_c();
        if ($urandom_range(0, 2) == 0)
            return C_W'(longint'($urandom_range(0, 1048575)) - 64'sd524288);
        return {$urandom, $urandom};
    endfunction

    // mostly in-range traffic with some out-of-range and spare words mixed in.
    // Reads of never-written C and computes over unwritten entries are turned
    // into writes, which walks the stores toward a state where both are legal.
    task automatic run_random(input int count);
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        int               n;
        int               pick;
        for (int i = 0; i < count; i++)
        begin
            n = active_size();
            if (n > 0 && $urandom_range(0, 99) < 85)
            begin
                row = IDX_W'($urandom_range(0, n - 1));
                col = IDX_W'($urandom_range(0, n - 1));
            end
            else
            begin
                row = IDX_W'($urandom_range(0, MAX_SIZE - 1));
                col = IDX_W'($urandom_range(0, MAX_SIZE - 1));
            end
            pick = $urandom_range(0, 99);
            if (pick < 22)
                op = OP_WRITE_A;
            else if (pick < 44)
                op = OP_WRITE_B;
            else if (pick < 58)
                op = OP_WRITE_C;
            else if (pick < 80)
                op = OP_READ_C;
            else if (pick < 87)
                op = OP_COMPUTE;
            else
                op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
            if (op == OP_READ_C && int'(row) < n && int'(col) < n &&
                !c_set[int'(row) * MAX_SIZE + int'(col)])
                op = OP_WRITE_C;
            if (op == OP_COMPUTE && !region_ready(n))
                op = OP_WRITE_A;
            send_word(op, row, col, rand_ab(), rand_c());
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // size comes out of reset at 32, so the far corner is in range
    task automatic test_reset_size();
        send_word(OP_WRITE_C, 5'd31, 5'd31, '0, C_MAX);
        send_word(OP_READ_C, 5'd31, 5'd31, '1, '1);
        send_word(OP_WRITE_A, 5'd31, 5'd31, AB_MIN, '0);
    endtask

    // bounds at size 8, C extremes, and the spare opcodes
    task automatic test_bounds_and_spare();
        set_size(CFG_W'(TILE));
        send_word(OP_WRITE_C, 5'd0, 5'd0, '0, C_MIN);
        send_word(OP_READ_C, 5'd0, 5'd0, '0, '0);
        send_word(OP_WRITE_C, 5'd7, 5'd7, '1, '0);
        send_word(OP_READ_C, 5'd7, 5'd7, '0, '0);
        send_word(OP_WRITE_A, 5'd8, 5'd0, AB_MAX, '0);
        send_word(OP_WRITE_B, 5'd0, 5'd8, AB_MIN, '0);
        // ignored write: the far corner must keep its old value
        send_word(OP_WRITE_C, 5'd31, 5'd31, '0, '0);
        send_word(OP_READ_C, 5'd31, 5'd31, '0, '0);
        send_word(OP_READ_C, 5'd8, 5'd0, '0, '0);
        send_word(OP_SPARE_FIRST, 5'd31, 5'd31, '1, '1);
        send_word(OP_SPARE_FIRST + 3'd1, 5'd0, 5'd0, '0, '0);
        send_word(OP_SPARE_LAST, 5'd3, 5'd4, rand_ab(), rand_c());
    endtask

    // sizes below one tile: n is zero, compute is a no-op, all access is out
    task automatic test_tiny_sizes();
        set_size(CFG_W'(TILE - 1));
        send_word(OP_COMPUTE, '0, '0, '0, '0);
        send_word(OP_WRITE_A, 5'd0, 5'd0, AB_MAX, '0);
        send_word(OP_READ_C, 5'd0, 5'd0, '0, '0);
        set_size('0);
        send_word(OP_COMPUTE, 5'd31, 5'd31, '1, '1);
        send_word(OP_READ_C, 5'd0, 5'd0, '0, '0);
    endtask

    // fill the 8 x 8 corner of all three stores in shuffled order
    task automatic test_preload();
        int               slots [$];
        int               j;
        int               tmp;
        logic [OP_W-1:0]  op;
        set_size(CFG_W'(TILE));
        for (int s = 0; s < 3; s++)
            for (int r = 0; r < TILE; r++)
                for (int c = 0; c < TILE; c++)
                    slots.push_back(s * DEPTH + r * MAX_SIZE + c);
        for (int i = slots.size() - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            tmp      = slots[i];
            slots[i] = slots[j];
            slots[j] = tmp;
        end
        foreach (slots[i])
        begin
            case (slots[i] / DEPTH)
                0:       op = OP_WRITE_A;
                1:       op = OP_WRITE_B;
                default: op = OP_WRITE_C;
            endcase
            send_word(op, IDX_W'((slots[i] % DEPTH) / MAX_SIZE),
                      IDX_W'(slots[i] % MAX_SIZE), rand_ab(), rand_c());
        end
    endtask

    // drive one C element into each rail through the accumulate
    task automatic test_saturation();
        for (int k = 0; k < TILE; k++)
        begin
            send_word(OP_WRITE_A, 5'd0, IDX_W'(k), AB_MAX, '0);
            send_word(OP_WRITE_B, IDX_W'(k), 5'd0, AB_MAX, '0);
        end
        send_word(OP_WRITE_C, 5'd0, 5'd0, '0, C_MAX - 64'sd5);
        send_word(OP_COMPUTE, '0, '0, '0, '0);
        send_word(OP_READ_C, 5'd0, 5'd0, '0, '0);
        for (int k = 0; k < TILE; k++)
            send_word(OP_WRITE_A, 5'd1, IDX_W'(k), AB_MIN, '0);
        send_word(OP_WRITE_C, 5'd1, 5'd0, '0, C_MIN + 64'sd5);
        send_word(OP_COMPUTE, '0, '0, '0, '0);
        send_word(OP_READ_C, 5'd1, 5'd0, '0, '0);
        send_word(OP_READ_C, 5'd0, 5'd0, '0, '0);
    endtask

    // receiver holds off long enough for the block to back up to its input
    task automatic test_backpressure();
        drain_results();
        @(posedge clk);
        stall_left = LONG_STALL;
        run_random(PRESSURE_WORDS);
    endtask

    // ------------------------------------------------------------------
    // Receiving side
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left  = stall_left - 1;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("word with nothing expected: read_value %h status %b",
                       m_tdata, m_tuser);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata !== want.read_value)
                begin
                    $error("read_value: expected %h, got %h", want.read_value,
                           m_tdata);
                    mismatch_count++;
                end
                if (m_tuser !== want.status)
                begin
                    $error("status: expected %b, got %b", want.status, m_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tuser        = '0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        size_reg       = SIZE_RESET;
        mismatch_count = 0;
        stall_left     = 0;
        tx_idle_pct    = 11;
        rx_idle_pct    = 48;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_size();
        test_bounds_and_spare();
        test_tiny_sizes();
        test_preload();
        test_saturation();
        run_random(RUN_WORDS);

        // swap the idle rates; 13 is not a tile multiple, so n stays 8
        drain_results();
        tx_idle_pct = 48;
        rx_idle_pct = 11;
        set_size(CFG_W'(13));
        run_random(RUN_WORDS);

        // full rate on both sides
        drain_results();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_backpressure();
        // 63 clamps to the full 32 x 32 matrix
        set_size('1);
        run_random(RUN_WORDS);

        drain_results();
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- sim.f -----
design/tmma_pkg.sv
design/tmma_ram.sv
design/tmma_mac.sv
design/tmma_seq.sv
design/tiled_matrix_multiply_accumulate_core.sv
test/tiled_matrix_multiply_accumulate_core_tb.sv
